// ----- rtl/bcia_pkg.sv -----
// Shared constants, types and helpers of the bundle cached index allocator.
package bcia_pkg;

  localparam int POOL_ENTRIES = 4096;
  localparam int BUNDLE_SIZE  = 64;
  localparam int NUM_CLIENTS  = 4;

  localparam int IDX_W   = 12;
  localparam int CLI_W   = 2;
  localparam int STAT_W  = 2;
  localparam int ADDR_W  = $clog2(POOL_ENTRIES);
  localparam int FRESH_W = $clog2(POOL_ENTRIES + 1);
  localparam int CNT_W   = $clog2(BUNDLE_SIZE + 1);
  localparam int CSEL_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FREE  = 2'd2;

  localparam logic [CNT_W-1:0]   BS_CNT    = CNT_W'(BUNDLE_SIZE);
  localparam logic [CNT_W-1:0]   BS_CNT_M1 = CNT_W'(BUNDLE_SIZE - 1);
  localparam logic [FRESH_W-1:0] BS_FRESH  = FRESH_W'(BUNDLE_SIZE);
  localparam logic [FRESH_W:0]   POOL_LIM  = (FRESH_W + 1)'(POOL_ENTRIES);

  // One RAM port set: one write and one read address per cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [IDX_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } bcia_mem_req_t;

  // Client number wraps modulo NUM_CLIENTS; the field is narrow.
  function automatic logic [CSEL_W-1:0] client_wrap(input logic [CLI_W-1:0] c);
    int v;
    v = int'(c);
    for (int i = 0; i < (1 << CLI_W) - 1; i++) begin
      if (v >= NUM_CLIENTS) begin
        v = v - NUM_CLIENTS;
      end
    end
    return CSEL_W'(v);
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    return ADDR_W'(idx);
  endfunction

endpackage

// ----- rtl/bundle_cached_index_allocator_top.sv -----
// Top level of the bundle cached index allocator: sequencer plus link RAMs.
//
// Index allocator over a pool of POOL_ENTRIES entries; index 0 means none.
// Each client (client wraps modulo NUM_CLIENTS) caches one full and one
// partial bundle of free entries, chained through the bundle chain RAM;
// surplus bundles sit on a shared stack chained through the stack link RAM.
// An item is taken when start is high and busy is low. Its result shows on
// alloc_index/status for exactly one cycle with done high; there is no
// backpressure, so the receiver must take it then.
// Sequencing, from the accept edge:
//   free (rejected, or good without a stack push), exhausted alloc: done in
//     the next cycle, busy stays low, so a new item can be taken every cycle.
//   good free whose overflow pushes the old full bundle onto the stack: done
//     in the next cycle, busy high for that one cycle while the freed
//     entry's stack link is cleared (the link RAM has one write port), so
//     no new item is taken meanwhile.
//   alloc served from a cached or stacked bundle: the chain RAM (and stack
//     link RAM for a pop) is read at the accept edge; busy for one cycle,
//     done in the cycle after it, and no new item is taken while busy.
//   alloc that carves a fresh bundle: BUNDLE_SIZE (64 at default) writes
//     through the single chain RAM write port, busy until the last one.
// Status: 0 ok, 1 pool exhausted, 2 free of index 0 or out of range.
// Link RAM contents are not cleared at reset and need no clearing pass:
// every entry is written before it can be read.
module bundle_cached_index_allocator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [bcia_pkg::CLI_W-1:0]  client,
  input  logic [bcia_pkg::IDX_W-1:0]  free_index,
  output logic                        done,
  output logic [bcia_pkg::IDX_W-1:0]  alloc_index,
  output logic [bcia_pkg::STAT_W-1:0] status
);
  import bcia_pkg::*;

  bcia_mem_req_t    chain_req;
  bcia_mem_req_t    link_req;
  logic [IDX_W-1:0] chain_rdata;
  logic [IDX_W-1:0] link_rdata;

  bcia_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .client      (client),
    .free_index  (free_index),
    .done        (done),
    .alloc_index (alloc_index),
    .status      (status),
    .chain_req   (chain_req),
    .chain_rdata (chain_rdata),
    .link_req    (link_req),
    .link_rdata  (link_rdata)
  );

  // next entry within a bundle
  bcia_ram #(.WIDTH(IDX_W), .DEPTH(POOL_ENTRIES)) u_chain_ram (
    .clk   (clk),
    .we    (chain_req.we),
    .waddr (chain_req.waddr),
    .wdata (chain_req.wdata),
    .raddr (chain_req.raddr),
    .rdata (chain_rdata)
  );

  // next bundle on the shared stack
  bcia_ram #(.WIDTH(IDX_W), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_req.we),
    .waddr (link_req.waddr),
    .wdata (link_req.wdata),
    .raddr (link_req.raddr),
    .rdata (link_rdata)
  );

  // index 0 is never linked
  a_chain_waddr_nonzero: assert property (@(posedge clk) disable iff (rst)
    chain_req.we |-> chain_req.waddr != '0)
    else $error("chain RAM write to index 0");

  a_link_waddr_nonzero: assert property (@(posedge clk) disable iff (rst)
    link_req.we |-> link_req.waddr != '0)
    else $error("stack link RAM write to index 0");

  a_error_no_index: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> alloc_index == '0)
    else $error("index returned with error status");

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy) || $past(busy))
    else $error("result without an item in progress");

endmodule

// ----- rtl/bcia_ram.sv -----
// Generic simple dual port RAM with registered read.
module bcia_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bcia_ctrl.sv -----
// Sequencer and per-client bundle caches; drives the chain and stack link RAMs.
module bcia_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [bcia_pkg::CLI_W-1:0]      client,
  input  logic [bcia_pkg::IDX_W-1:0]      free_index,
  output logic                            done,
  output logic [bcia_pkg::IDX_W-1:0]      alloc_index,
  output logic [bcia_pkg::STAT_W-1:0]     status,
  output bcia_pkg::bcia_mem_req_t         chain_req,
  input  logic [bcia_pkg::IDX_W-1:0]      chain_rdata,
  output bcia_pkg::bcia_mem_req_t         link_req,
  input  logic [bcia_pkg::IDX_W-1:0]      link_rdata
);
  import bcia_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FINISH = 2'd1;
  localparam logic [1:0] S_CARVE  = 2'd2;
  localparam logic [1:0] S_CLEAR  = 2'd3;

  logic [1:0]         state;
  logic [CSEL_W-1:0]  client_q;
  logic [IDX_W-1:0]   head_q;
  logic               from_part;
  logic               pop_q;
  logic [FRESH_W-1:0] carve_ptr;
  logic [FRESH_W-1:0] carve_last;

  logic [IDX_W-1:0]   full_bnd [NUM_CLIENTS];
  logic [IDX_W-1:0]   part_bnd [NUM_CLIENTS];
  logic [CNT_W-1:0]   part_cnt [NUM_CLIENTS];
  logic [IDX_W-1:0]   stack_head;
  logic [FRESH_W-1:0] next_fresh;

  logic [CSEL_W-1:0]  c_in;
  logic [CSEL_W-1:0]  sel;
  logic [IDX_W-1:0]   cur_full;
  logic [IDX_W-1:0]   cur_part;
  logic [CNT_W-1:0]   cur_cnt;
  logic [IDX_W-1:0]   head_sel;
  logic [FRESH_W:0]   fresh_end;
  logic               exhausted;
  logic               idx_bad;
  logic               ovf;

  assign busy      = (state != S_IDLE);
  assign c_in      = client_wrap(client);
  assign sel       = (state == S_IDLE) ? c_in : client_q;
  assign cur_full  = full_bnd[sel];
  assign cur_part  = part_bnd[sel];
  assign cur_cnt   = part_cnt[sel];
  assign head_sel  = (cur_part != '0) ? cur_part :
                     (cur_full != '0) ? cur_full : stack_head;
  assign fresh_end = {1'b0, next_fresh} + (FRESH_W + 1)'(BUNDLE_SIZE);
  assign exhausted = (fresh_end > POOL_LIM);
  assign idx_bad   = (free_index == '0) || ((FRESH_W + 1)'(free_index) >= POOL_LIM);
  assign ovf       = (cur_cnt >= BS_CNT);

  always_comb begin
    chain_req       = '0;
    link_req        = '0;
    chain_req.raddr = to_addr(head_sel);
    link_req.raddr  = to_addr(stack_head);
    case (state)
      S_IDLE: begin
        if (start && func == FUNC_FREE && !idx_bad) begin
          chain_req.we    = 1'b1;
          chain_req.waddr = to_addr(free_index);
          chain_req.wdata = ovf ? '0 : cur_part;
          // overflow pushes the old full bundle (if any) onto the shared stack and
          // the freed entry's stack link is cleared afterwards; otherwise at once
          if (ovf && cur_full != '0) begin
            link_req.we    = 1'b1;
            link_req.waddr = to_addr(cur_full);
            link_req.wdata = stack_head;
          end else begin
            link_req.we    = 1'b1;
            link_req.waddr = to_addr(free_index);
            link_req.wdata = '0;
          end
        end
      end
      S_FINISH: begin
        chain_req.we    = 1'b1;
        chain_req.waddr = to_addr(head_q);
        chain_req.wdata = '0;
        // popped bundle drops its stack link
        if (pop_q) begin
          link_req.we    = 1'b1;
          link_req.waddr = to_addr(head_q);
          link_req.wdata = '0;
        end
      end
      S_CARVE: begin
        chain_req.we    = 1'b1;
        chain_req.waddr = ADDR_W'(carve_ptr);
        chain_req.wdata = (carve_ptr == next_fresh || carve_ptr == carve_last) ? '0 :
                          IDX_W'(carve_ptr - FRESH_W'(1));
      end
      S_CLEAR: begin
        link_req.we    = 1'b1;
        link_req.waddr = to_addr(head_q);
        link_req.wdata = '0;
      end
      default: begin
        chain_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      stack_head <= '0;
      next_fresh <= FRESH_W'(1);
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        full_bnd[i] <= '0;
        part_bnd[i] <= '0;
        part_cnt[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            client_q <= c_in;
            if (func == FUNC_ALLOC) begin
              if (cur_part != '0) begin
                head_q    <= cur_part;
                from_part <= 1'b1;
                pop_q     <= 1'b0;
                state     <= S_FINISH;
              end else if (cur_full != '0) begin
                head_q         <= cur_full;
                full_bnd[c_in] <= '0;
                from_part      <= 1'b0;
                pop_q          <= 1'b0;
                state          <= S_FINISH;
              end else if (stack_head != '0) begin
                head_q    <= stack_head;
                from_part <= 1'b0;
                pop_q     <= 1'b1;
                state     <= S_FINISH;
              end else if (exhausted) begin
                done        <= 1'b1;
                alloc_index <= '0;
                status      <= ST_EXHAUSTED;
              end else begin
                carve_ptr  <= next_fresh;
                carve_last <= next_fresh + BS_FRESH - FRESH_W'(1);
                state      <= S_CARVE;
              end
            end else if (idx_bad) begin
              done        <= 1'b1;
              alloc_index <= '0;
              status      <= ST_BAD_FREE;
            end else begin
              if (ovf) begin
                if (cur_full != '0) begin
                  stack_head <= cur_full;
                  state      <= S_CLEAR;
                end
                full_bnd[c_in] <= cur_part;
              end
              head_q         <= free_index;
              part_bnd[c_in] <= free_index;
              part_cnt[c_in] <= (ovf ? '0 : cur_cnt) + CNT_W'(1);
              done           <= 1'b1;
              alloc_index    <= '0;
              status         <= ST_OK;
            end
          end
        end
        S_FINISH: begin
          part_bnd[client_q] <= chain_rdata;
          if (from_part) begin
            part_cnt[client_q] <= (cur_cnt != '0) ? cur_cnt - CNT_W'(1) : '0;
          end else begin
            part_cnt[client_q] <= BS_CNT_M1;
          end
          if (pop_q) begin
            stack_head <= link_rdata;
          end
          done        <= 1'b1;
          alloc_index <= head_q;
          status      <= ST_OK;
          state       <= S_IDLE;
        end
        S_CARVE: begin
          carve_ptr <= carve_ptr + FRESH_W'(1);
          if (carve_ptr == carve_last) begin
            part_bnd[client_q] <= IDX_W'(carve_last - FRESH_W'(1));
            part_cnt[client_q] <= BS_CNT_M1;
            next_fresh         <= next_fresh + BS_FRESH;
            done               <= 1'b1;
            alloc_index        <= IDX_W'(carve_last);
            status             <= ST_OK;
            state              <= S_IDLE;
          end
        end
        S_CLEAR: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- test/tb_bundle_cached_index_allocator_top.sv -----
// Self-checking testbench of the bundle cached index allocator top level.
`timescale 1ns / 100ps

module tb_bundle_cached_index_allocator_top;
  import bcia_pkg::*;

  // Generous cycle budget for the whole run.
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int          MIX_ITEMS = 750;
  localparam int          TAIL_MIX  = 150;

  // One request item as queued for the driver.
  typedef struct {
    logic              fn;
    logic [CLI_W-1:0]  cl;
    logic [IDX_W-1:0]  idx;
  } alloc_req_t;

  // Expected answer of one accepted item; cl is kept to file granted indices.
  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [STAT_W-1:0] st;
    logic [CLI_W-1:0]  cl;
  } grant_t;

  // An index currently handed out, with the client that got it.
  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [CLI_W-1:0]  cl;
  } held_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              func = FUNC_ALLOC;
  logic [CLI_W-1:0]  client = '0;
  logic [IDX_W-1:0]  free_index = '0;
  logic              busy;
  logic              done;
  logic [IDX_W-1:0]  alloc_index;
  logic [STAT_W-1:0] status;

  alloc_req_t  req_q[$];     // items waiting for the driver
  grant_t      grant_q[$];   // answers owed by the block, oldest first
  held_t       held_q[$];    // indices out in the field, fodder for frees
  logic        drained = 1'b1;
  int          gap_left = 0;
  int          burst_left = 0;
  int          fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Shadow of the allocator state.
  logic [IDX_W-1:0]   chain_mem [POOL_ENTRIES];
  logic [IDX_W-1:0]   stack_mem [POOL_ENTRIES];
  logic [IDX_W-1:0]   full_hd   [NUM_CLIENTS];
  logic [IDX_W-1:0]   part_hd   [NUM_CLIENTS];
  logic [CNT_W-1:0]   part_cnt  [NUM_CLIENTS];
  logic [IDX_W-1:0]   stack_top;
  logic [FRESH_W-1:0] fresh_ptr;

  bundle_cached_index_allocator_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .client      (client),
    .free_index  (free_index),
    .done        (done),
    .alloc_index (alloc_index),
    .status      (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Reload an empty partial bundle of client c: full bundle first, then the
  // shared stack, then a fresh carve from the bump pointer. 0 = exhausted.
  function automatic bit refill_partial(int c);
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] prev;
    int               e;
    if (full_hd[c] != '0) begin
      part_hd[c] = full_hd[c];
      full_hd[c] = '0;
    end else if (stack_top != '0) begin
      top = stack_top;
      stack_top = stack_mem[top];
      stack_mem[top] = '0;
      part_hd[c] = top;
    end else begin
      if (int'(fresh_ptr) + BUNDLE_SIZE > POOL_ENTRIES) begin
        return 1'b0;
      end
      // Carved chain runs downward: the last carved entry is the head.
      prev = '0;
      for (int i = 0; i < BUNDLE_SIZE; i++) begin
        e = int'(fresh_ptr) + i;
        chain_mem[e % POOL_ENTRIES] = prev;
        stack_mem[e % POOL_ENTRIES] = '0;
        prev = IDX_W'(e);
      end
      part_hd[c] = prev;
      fresh_ptr = fresh_ptr + BS_FRESH;
    end
    part_cnt[c] = BS_CNT;
    return 1'b1;
  endfunction

  // Works out the answer to one item and moves the shadow state on.
  function automatic grant_t predict_grant(input logic fn, input logic [CLI_W-1:0] cl,
                                           input logic [IDX_W-1:0] fidx);
    grant_t g;
    int     c;
    c = int'(cl) % NUM_CLIENTS;
    g.idx = '0;
    g.st  = ST_OK;
    g.cl  = cl;
    if (fn == FUNC_ALLOC) begin
      if (part_hd[c] == '0) begin
        if (!refill_partial(c)) begin
          g.st = ST_EXHAUSTED;
        end
      end
      if (g.st == ST_OK) begin
        g.idx = part_hd[c];
        part_hd[c] = chain_mem[g.idx];
        // count saturates at zero when a chain outlives it
        if (part_cnt[c] != '0) begin
          part_cnt[c] = part_cnt[c] - 1'b1;
        end
        chain_mem[g.idx] = '0;
      end
    end else if (fidx == '0 || int'(fidx) >= POOL_ENTRIES) begin
      g.st = ST_BAD_FREE;
    end else begin
      // Partial bundle full: it becomes the full one, old full goes to the stack.
      if (int'(part_cnt[c]) >= BUNDLE_SIZE) begin
        if (full_hd[c] != '0) begin
          stack_mem[full_hd[c]] = stack_top;
          stack_top = full_hd[c];
        end
        full_hd[c] = part_hd[c];
        part_hd[c] = '0;
        part_cnt[c] = '0;
      end
      stack_mem[fidx] = '0;
      chain_mem[fidx] = part_hd[c];
      part_hd[c] = fidx;
      part_cnt[c] = part_cnt[c] + 1'b1;
    end
    return g;
  endfunction

  // Driver: holds an item until start && !busy, then moves straight on to
  // the next one inside a burst, or drops start for the gap after it.
  always @(posedge clk) begin
    alloc_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        start <= 1'b1;
        func <= nxt.fn;
        client <= nxt.cl;
        free_index <= nxt.idx;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left <= 0;
            7:       gap_left <= $urandom_range(10, 20);
            default: gap_left <= $urandom_range(1, 6);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks the result of this cycle against the oldest answer owed,
  // then predicts the item taken at this edge. A result can never belong to
  // the item accepted at the same edge, so check comes first.
  always @(posedge clk) begin
    grant_t exp_g;
    if (rst) begin
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        chain_mem[i] = '0;
        stack_mem[i] = '0;
      end
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        full_hd[i]  = '0;
        part_hd[i]  = '0;
        part_cnt[i] = '0;
      end
      stack_top = '0;
      fresh_ptr = FRESH_W'(1);
      drained <= 1'b1;
    end else begin
      if (done) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result: alloc_index %0d status %0d", alloc_index, status);
          fail_cnt++;
        end else begin
          exp_g = grant_q.pop_front();
          if (alloc_index !== exp_g.idx) begin
            $error("alloc_index: expected %0d actual %0d", exp_g.idx, alloc_index);
            fail_cnt++;
          end
          if (status !== exp_g.st) begin
            $error("status: expected %0d actual %0d", exp_g.st, status);
            fail_cnt++;
          end
          if (exp_g.st == ST_OK && exp_g.idx != '0) begin
            held_q.push_back('{exp_g.idx, exp_g.cl});
          end
        end
      end
      if (start && !busy) begin
        grant_q.push_back(predict_grant(func, client, free_index));
      end
      drained <= (grant_q.size() == 0);
    end
  end

  // Keeps the driver queue short so frees pick from fresh grants.
  task automatic queue_req(input logic fn, input int cl, input logic [IDX_W-1:0] idx);
    while (req_q.size() >= 4) begin
      @(negedge clk);
    end
    req_q.push_back('{fn, CLI_W'(cl), idx});
  endtask

  // Sender pause: nothing queued, nothing on the port, every answer in.
  task automatic settle();
    do begin
      @(negedge clk);
    end while (!(req_q.size() == 0 && !start && drained && grant_q.size() == 0));
  endtask

  // Random workload in episodes: a client grabs a batch, later batches of
  // held indices come back, sometimes to other clients; stray frees of
  // random indices, index zero and double frees are sprinkled in.
  task automatic run_mix(input int target);
    int    sent;
    int    n;
    int    c;
    int    k;
    int    mode;
    held_t lv;
    sent = 0;
    while (sent < target) begin
      c = $urandom_range(0, NUM_CLIENTS - 1);
      mode = $urandom_range(0, 99);
      if (mode < 45) begin
        n = $urandom_range(1, 80);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 19))
            0: queue_req(FUNC_FREE, $urandom_range(0, 3), IDX_W'($urandom_range(0, 4095)));
            1: queue_req(FUNC_FREE, $urandom_range(0, 3), '0);
            2: begin
              if (held_q.size() != 0) begin
                lv = held_q[$urandom_range(0, held_q.size() - 1)];
                queue_req(FUNC_FREE, $urandom_range(0, 3), lv.idx);
              end
            end
            3: queue_req(FUNC_ALLOC, $urandom_range(0, 3), IDX_W'($urandom));
            default: queue_req(FUNC_ALLOC, c, IDX_W'($urandom));
          endcase
        end
        sent += n;
      end else if (mode < 90) begin
        settle();
        n = (held_q.size() == 0) ? 0 : $urandom_range(1, held_q.size());
        mode = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) begin
          k = $urandom_range(0, held_q.size() - 1);
          lv = held_q[k];
          held_q.delete(k);
          if (mode < 5) begin
            queue_req(FUNC_FREE, lv.cl, lv.idx);
          end else if (mode < 8) begin
            queue_req(FUNC_FREE, c, lv.idx);
          end else begin
            queue_req(FUNC_FREE, $urandom_range(0, 3), lv.idx);
          end
        end
        sent += n;
      end else begin
        for (int i = 0; i < 16; i++) begin
          if ($urandom_range(0, 1) == 0) begin
            queue_req(FUNC_ALLOC, $urandom_range(0, 3), IDX_W'($urandom));
          end else begin
            queue_req(FUNC_FREE, $urandom_range(0, 3), IDX_W'($urandom));
          end
        end
        sent += 16;
      end
    end
  endtask

  // Drains the pool through client c: each cached bundle is cut short by
  // freeing its own head (a self loop), so two allocs empty it and the
  // next alloc has to refill. Ends on an exhausted alloc.
  task automatic burn_pool(input int c);
    int guard;
    guard = 0;
    settle();
    while (!(part_hd[c] == '0 && full_hd[c] == '0 && stack_top == '0 &&
             int'(fresh_ptr) + BUNDLE_SIZE > POOL_ENTRIES) && guard < 2000) begin
      if (part_hd[c] == '0 || int'(part_cnt[c]) >= BUNDLE_SIZE) begin
        queue_req(FUNC_ALLOC, c, IDX_W'($urandom));
      end else begin
        queue_req(FUNC_FREE, c, part_hd[c]);
        queue_req(FUNC_ALLOC, c, IDX_W'($urandom));
        queue_req(FUNC_ALLOC, c, IDX_W'($urandom));
      end
      settle();
      guard++;
    end
    queue_req(FUNC_ALLOC, c, IDX_W'($urandom));
    queue_req(FUNC_ALLOC, c, '1);
  endtask

  // Stimulus and end of run.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Count saturation: client 0 gets a one-entry partial bundle whose chain
    // is then extended through client 1, so the second alloc runs at count 0.
    queue_req(FUNC_FREE, 1, 12'h100);
    queue_req(FUNC_FREE, 0, 12'h0FF);
    queue_req(FUNC_FREE, 1, 12'h0FF);
    queue_req(FUNC_ALLOC, 0, 12'hFFF);
    queue_req(FUNC_ALLOC, 0, 12'h000);
    // Empty caches carve fresh bundles; client 1 first hands out its cached entry.
    queue_req(FUNC_ALLOC, 0, 12'h123);
    queue_req(FUNC_ALLOC, 1, 12'h000);
    queue_req(FUNC_ALLOC, 1, 12'hFFF);
    queue_req(FUNC_ALLOC, 2, 12'h000);
    // Free of index zero is rejected with a bad-free status.
    queue_req(FUNC_FREE, 0, 12'h000);
    // Top index, never carved, freed then handed back.
    queue_req(FUNC_FREE, 3, 12'hFFF);
    queue_req(FUNC_ALLOC, 3, 12'h000);
    queue_req(FUNC_ALLOC, 3, 12'hFFF);
    queue_req(FUNC_FREE, 2, 12'hAAA);
    queue_req(FUNC_FREE, 1, 12'h555);
    queue_req(FUNC_ALLOC, 2, 12'h555);
    queue_req(FUNC_ALLOC, 1, 12'hAAA);

    run_mix(MIX_ITEMS);

    // Pool exhaustion, then allocs on every client and a last mixed stretch.
    burn_pool(2);
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      queue_req(FUNC_ALLOC, i, IDX_W'($urandom));
    end
    run_mix(TAIL_MIX);

    settle();
    repeat (BUNDLE_SIZE + 8) @(negedge clk);
    if (grant_q.size() != 0) begin
      $error("%0d results never arrived", grant_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
